// ----- rtl/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants of the button debounce and long-press unit.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_DEBOUNCE = 5'b00010,
        MODE_PRESSED  = 5'b00100,
        MODE_LONG     = 5'b01000,
        MODE_REPEAT   = 5'b10000
    } mode_t;

    localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_CODE_DEBOUNCE = 3'd1;
    localparam logic [2:0] MODE_CODE_PRESSED  = 3'd2;
    localparam logic [2:0] MODE_CODE_LONG     = 3'd3;
    localparam logic [2:0] MODE_CODE_REPEAT   = 3'd4;

    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_SHORT        = 3'd1;
    localparam logic [2:0] EV_LONG         = 3'd2;
    localparam logic [2:0] EV_LONG_RELEASE = 3'd3;
    localparam logic [2:0] EV_REPEAT       = 3'd4;

    localparam logic [1:0] CFG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE     = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS   = 2'd2;
    localparam logic [1:0] CFG_REPEAT       = 2'd3;

    localparam logic        RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [15:0] RST_REPEAT       = 16'd200;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_DEBOUNCE: c = MODE_CODE_DEBOUNCE;
            MODE_PRESSED:  c = MODE_CODE_PRESSED;
            MODE_LONG:     c = MODE_CODE_LONG;
            MODE_REPEAT:   c = MODE_CODE_REPEAT;
            default:       c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/button_debounce_long_press_unit.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit
// Debounces a sampled button pin, one beat per tick, and reports short press,
// long press, repeat and long release events with the current mode.
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  s_axis  | in        | tdata[0] pin_level               | tvalid/tready
//  m_axis  | out       | tdata[2:0] event_res, [5:3] mode | tvalid/tready
//  cfg     | in        | cfg_index, cfg_data              | cfg_we, no wait
//
//  One beat per clock sustained while m_axis is not stalled; a beat waits in
//  the input register and its result is loaded into the output register.
//  The mode and tick counter update in the same step that loads the result.
//  Reset (synchronous, aresetn low) returns to idle, counter zero, default
//  registers. A stalled output holds the input register, then s_axis_tready.
// ----------------------------------------------------------------------------
module button_debounce_long_press_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] event_res, [5:3] mode_now, [7:6] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        active_level_reg;
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [15:0] repeat_reg;

    logic        in_valid_reg;
    logic        in_pin_reg;
    logic        out_valid_reg;
    logic [2:0]  out_event_reg;
    logic [2:0]  out_mode_reg;

    bdlp_pkg::mode_t mode_reg, mode_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [2:0]  event_next;

    logic        advance;
    logic        pushed;
    logic        mark;
    logic [15:0] d;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_mode_reg, out_event_reg};

    assign pushed = (in_pin_reg == active_level_reg);
    assign d      = (elapsed_reg == bdlp_pkg::TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    always_comb begin
        mode_next  = mode_reg;
        event_next = bdlp_pkg::EV_NONE;
        mark       = 1'b0;
        case (mode_reg)
            bdlp_pkg::MODE_DEBOUNCE: begin
                if (d >= debounce_reg) begin
                    if (!pushed) begin
                        mode_next = bdlp_pkg::MODE_IDLE;
                    end else begin
                        mode_next = bdlp_pkg::MODE_PRESSED;
                        mark      = 1'b1;
                    end
                end
            end
            bdlp_pkg::MODE_PRESSED: begin
                if (!pushed) begin
                    mode_next  = bdlp_pkg::MODE_IDLE;
                    event_next = bdlp_pkg::EV_SHORT;
                end else if (d >= long_press_reg) begin
                    mode_next  = bdlp_pkg::MODE_LONG;
                    event_next = bdlp_pkg::EV_LONG;
                    mark       = 1'b1;
                end
            end
            bdlp_pkg::MODE_LONG, bdlp_pkg::MODE_REPEAT: begin
                if (!pushed) begin
                    mode_next  = bdlp_pkg::MODE_IDLE;
                    event_next = bdlp_pkg::EV_LONG_RELEASE;
                end else if (d >= repeat_reg) begin
                    mode_next  = bdlp_pkg::MODE_REPEAT;
                    event_next = bdlp_pkg::EV_REPEAT;
                    mark       = 1'b1;
                end
            end
            default: begin
                if (pushed) begin
                    mode_next = bdlp_pkg::MODE_DEBOUNCE;
                    mark      = 1'b1;
                end else begin
                    mode_next = bdlp_pkg::MODE_IDLE;
                end
            end
        endcase
        elapsed_next = mark ? 16'd0 : d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= bdlp_pkg::RST_ACTIVE_LEVEL;
            debounce_reg     <= bdlp_pkg::RST_DEBOUNCE;
            long_press_reg   <= bdlp_pkg::RST_LONG_PRESS;
            repeat_reg       <= bdlp_pkg::RST_REPEAT;
        end else if (cfg_we) begin
            case (cfg_index)
                bdlp_pkg::CFG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                bdlp_pkg::CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                bdlp_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                bdlp_pkg::CFG_REPEAT:       repeat_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bdlp_pkg::MODE_IDLE;
            elapsed_reg   <= 16'd0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                elapsed_reg   <= elapsed_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_pin_reg <= s_axis_tdata[0];
        end
        if (advance) begin
            out_event_reg <= event_next;
            out_mode_reg  <= bdlp_pkg::mode_code(mode_next);
        end
    end

endmodule

// ----- verif/button_event_checker.sv -----
// ----------------------------------------------------------------------------
// button_event_checker
// Watches the tick, result and register ports of the debounce unit, predicts
// the event code and mode of every accepted tick beat, and compares each
// result beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module button_event_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [2:0] event_res, [5:3] mode_now, [7:6] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] ev_code;
        logic [2:0] mode_code;
    } tick_outcome_t;

    logic          active_lvl   = bdlp_pkg::RST_ACTIVE_LEVEL;
    logic [15:0]   debounce_lim = bdlp_pkg::RST_DEBOUNCE;
    logic [15:0]   long_lim     = bdlp_pkg::RST_LONG_PRESS;
    logic [15:0]   repeat_lim   = bdlp_pkg::RST_REPEAT;
    logic [2:0]    btn_mode     = bdlp_pkg::MODE_CODE_IDLE;
    logic [15:0]   btn_ticks    = '0;
    tick_outcome_t awaited_outcomes[$];
    int            fail_count   = 0;

    function automatic tick_outcome_t debounce_step(input logic pin);
        logic          pushed;
        logic [15:0]   d;
        logic          mark;
        tick_outcome_t r;
        pushed    = (pin == active_lvl);
        d         = (btn_ticks == bdlp_pkg::TICK_MAX) ? bdlp_pkg::TICK_MAX
                                                      : btn_ticks + 16'd1;
        mark      = 1'b0;
        r.ev_code = bdlp_pkg::EV_NONE;
        case (btn_mode)
            bdlp_pkg::MODE_CODE_DEBOUNCE: begin
                if (d >= debounce_lim) begin
                    if (pushed) begin
                        btn_mode = bdlp_pkg::MODE_CODE_PRESSED;
                        mark     = 1'b1;
                    end else begin
                        btn_mode = bdlp_pkg::MODE_CODE_IDLE;
                    end
                end
            end
            bdlp_pkg::MODE_CODE_PRESSED: begin
                if (!pushed) begin
                    btn_mode  = bdlp_pkg::MODE_CODE_IDLE;
                    r.ev_code = bdlp_pkg::EV_SHORT;
                end else if (d >= long_lim) begin
                    btn_mode  = bdlp_pkg::MODE_CODE_LONG;
                    mark      = 1'b1;
                    r.ev_code = bdlp_pkg::EV_LONG;
                end
            end
            bdlp_pkg::MODE_CODE_LONG, bdlp_pkg::MODE_CODE_REPEAT: begin
                if (!pushed) begin
                    btn_mode  = bdlp_pkg::MODE_CODE_IDLE;
                    r.ev_code = bdlp_pkg::EV_LONG_RELEASE;
                end else if (d >= repeat_lim) begin
                    btn_mode  = bdlp_pkg::MODE_CODE_REPEAT;
                    mark      = 1'b1;
                    r.ev_code = bdlp_pkg::EV_REPEAT;
                end
            end
            default: begin
                if (pushed) begin
                    btn_mode = bdlp_pkg::MODE_CODE_DEBOUNCE;
                    mark     = 1'b1;
                end else begin
                    btn_mode = bdlp_pkg::MODE_CODE_IDLE;
                end
            end
        endcase
        btn_ticks   = mark ? 16'd0 : d;
        r.mode_code = btn_mode;
        return r;
    endfunction

    always @(posedge aclk) begin
        tick_outcome_t want;
        tick_outcome_t got;
        if (!aresetn) begin
            active_lvl   = bdlp_pkg::RST_ACTIVE_LEVEL;
            debounce_lim = bdlp_pkg::RST_DEBOUNCE;
            long_lim     = bdlp_pkg::RST_LONG_PRESS;
            repeat_lim   = bdlp_pkg::RST_REPEAT;
            btn_mode     = bdlp_pkg::MODE_CODE_IDLE;
            btn_ticks    = '0;
            awaited_outcomes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bdlp_pkg::CFG_ACTIVE_LEVEL: active_lvl   = cfg_data[0];
                    bdlp_pkg::CFG_DEBOUNCE:     debounce_lim = cfg_data;
                    bdlp_pkg::CFG_LONG_PRESS:   long_lim     = cfg_data;
                    bdlp_pkg::CFG_REPEAT:       repeat_lim   = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_outcomes.push_back(debounce_step(s_axis_tdata[0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.ev_code   = m_axis_tdata[2:0];
                got.mode_code = m_axis_tdata[5:3];
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got event %0d mode %0d",
                             $time, got.ev_code, got.mode_code);
                    fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got.ev_code !== want.ev_code) begin
                        $display("%0t: event_res mismatch, expected %0d, got %0d",
                                 $time, want.ev_code, got.ev_code);
                        fail_count++;
                    end
                    if (got.mode_code !== want.mode_code) begin
                        $display("%0t: mode_now mismatch, expected %0d, got %0d",
                                 $time, want.mode_code, got.mode_code);
                        fail_count++;
                    end
                end
            end
        end
        pending    <= awaited_outcomes.size();
        mismatches <= fail_count;
    end

endmodule

// ----- verif/button_debounce_long_press_unit_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit_tb
// Drives tick beats and register writes into the debounce unit: reset
// defaults, zero limits, a release hidden in the debounce wait, the largest
// limits, then random presses and bounces under four mixes of sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module button_debounce_long_press_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100_000;
    localparam int RANDOM_TICKS_PER_PHASE = 270;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [0] pin_level, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [2:0] event_res, [5:3] mode_now, [7:6] zero
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = bdlp_pkg::CFG_ACTIVE_LEVEL;
    logic [15:0] cfg_data      = '0;

    int          mismatches;
    int          pending;
    int          cycles        = 0;
    int          ticks_sent    = 0;
    int          settings_used = 1;
    int          sender_idle_pct = 0;
    int          sink_stall_pct  = 0;
    logic        act_now       = bdlp_pkg::RST_ACTIVE_LEVEL;
    int          lim_db        = bdlp_pkg::RST_DEBOUNCE;
    int          lim_lp        = bdlp_pkg::RST_LONG_PRESS;
    int          lim_rp        = bdlp_pkg::RST_REPEAT;

    button_debounce_long_press_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    button_event_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_level(input logic lvl);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, lvl};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    task automatic hold(input logic pushed, input int n);
        repeat (n) send_level(pushed ? act_now : ~act_now);
    endtask

    // drain, then write all four registers
    task automatic load_registers(input logic al, input logic [15:0] db,
                                  input logic [15:0] lp, input logic [15:0] rp);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = bdlp_pkg::CFG_ACTIVE_LEVEL;
        cfg_data  = {15'($urandom), al};
        @(negedge aclk);
        cfg_index = bdlp_pkg::CFG_DEBOUNCE;
        cfg_data  = db;
        @(negedge aclk);
        cfg_index = bdlp_pkg::CFG_LONG_PRESS;
        cfg_data  = lp;
        @(negedge aclk);
        cfg_index = bdlp_pkg::CFG_REPEAT;
        cfg_data  = rp;
        @(negedge aclk);
        cfg_we  = 1'b0;
        act_now = al;
        lim_db  = db;
        lim_lp  = lp;
        lim_rp  = rp;
        settings_used++;
    endtask

    task automatic random_gesture();
        if ($urandom_range(99) < 80) begin
            hold(1'b0, $urandom_range(0, 3));
            hold(1'b1, $urandom_range(0, lim_db + lim_lp + 3 * lim_rp + 6));
            hold(1'b0, $urandom_range(1, 3));
        end else begin
            repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int goal;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: debounce of twenty, then a short press
        hold(1'b1, 22);
        hold(1'b0, 1);

        // zero limits: every wait ends on the first tick after the mark
        load_registers(1'b1, 16'd0, 16'd0, 16'd0);
        hold(1'b1, 5);
        hold(1'b0, 1);
        hold(1'b1, 1);
        hold(1'b0, 1);
        hold(1'b1, 2);
        hold(1'b0, 1);

        // release inside the debounce wait goes unseen
        load_registers(1'b0, 16'd3, 16'd2, 16'd1);
        hold(1'b1, 1);
        hold(1'b0, 1);
        hold(1'b1, 4);
        hold(1'b0, 1);

        // largest limits: the debounce wait never ends within the hold
        load_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        hold(1'b1, 30);
        hold(1'b0, 2);

        goal = ticks_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin sender_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            for (int half = 0; half < 2; half++) begin
                load_registers(1'($urandom_range(0, 1)), 16'($urandom_range(0, 4)),
                               16'($urandom_range(0, 10)), 16'($urandom_range(0, 5)));
                goal += RANDOM_TICKS_PER_PHASE / 2;
                while (ticks_sent < goal) random_gesture();
            end
        end

        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge aclk);
        $display("%0d tick beats over %0d register settings, incl. zero and full-range limits,",
                 ticks_sent, settings_used);
        $display("with sender gaps and receiver stalls mixed in four phases");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
